// ===== hw/rtl/dasc_pkg.sv =====
// Shared widths, ASCII codes and sequencer states of the decimal ASCII printer.
`default_nettype none

package dasc_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned DIGIT_COUNT = 10;
   localparam int unsigned BCD_WIDTH   = 4 * DIGIT_COUNT;
   localparam int unsigned SHIFT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int unsigned DIGIT_CNT_WIDTH = $clog2(DIGIT_COUNT + 1);

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CONVERT = 5'b00010,
      ST_ALIGN   = 5'b00100,
      ST_SIGN    = 5'b01000,
      ST_EMIT    = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dasc_req_if.sv =====
// Valid/ready channel carrying one signed integer per transaction.
`default_nettype none

interface dasc_req_if;

   logic                                       valid;
   logic                                       ready;
   logic signed [dasc_pkg::VALUE_WIDTH-1:0]    value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/dasc_rsp_if.sv =====
// Valid/ready channel carrying one ASCII character per transaction.
`default_nettype none

interface dasc_rsp_if;

   logic                               valid;
   logic                               ready;
   logic [dasc_pkg::CHAR_WIDTH-1:0]    character;
   logic                               last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// Steps: double-dabble shift-and-correct over the 32-bit magnitude, one magnitude bit per shift,
// then align steps that drop leading zero digits, a sign step when negative, then one character
// per cycle while the receiver does not stall. A new number is taken only once the last
// character of the previous one has been placed in the output register.
// Input ready is high only while the sequencer is idle; the output register holds one character.
// Reset (synchronous, active high) returns the sequencer to idle and drops any pending character.
`default_nettype none

module int_to_decimal_ascii (
   input  wire         clock,
   input  wire         reset,
   dasc_req_if.sink    req_chan,
   dasc_rsp_if.source  rsp_chan
);

   dasc_pkg::state_type state_ff, state_in;

   logic [dasc_pkg::VALUE_WIDTH-1:0]      mag_ff, mag_in;
   logic [dasc_pkg::BCD_WIDTH-1:0]        bcd_ff, bcd_in;
   logic [dasc_pkg::BCD_WIDTH-1:0]        bcd_adj;
   logic                                  neg_ff, neg_in;
   logic [dasc_pkg::SHIFT_CNT_WIDTH-1:0]  shift_cnt_ff, shift_cnt_in;
   logic [dasc_pkg::DIGIT_CNT_WIDTH-1:0]  digits_ff, digits_in;

   logic                                  out_valid_ff, out_valid_in;
   logic [dasc_pkg::CHAR_WIDTH-1:0]       out_char_ff, out_char_in;
   logic                                  out_last_ff, out_last_in;

   logic                                  req_accept;
   logic                                  slot_free;
   logic [3:0]                            top_digit;
   logic                                  last_digit;

   assign req_chan.ready = (state_ff == dasc_pkg::ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign slot_free      = !out_valid_ff || rsp_chan.ready;
   assign top_digit      = bcd_ff[dasc_pkg::BCD_WIDTH-1 -: 4];
   assign last_digit     = (digits_ff == dasc_pkg::DIGIT_CNT_WIDTH'(1));

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.character = out_char_ff;
   assign rsp_chan.last      = out_last_ff;

   always_comb begin
      for (int i = 0; i < dasc_pkg::DIGIT_COUNT; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      shift_cnt_in = shift_cnt_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         dasc_pkg::ST_IDLE: begin
            if (req_accept) begin
               neg_in       = req_chan.value[dasc_pkg::VALUE_WIDTH-1];
               mag_in       = req_chan.value[dasc_pkg::VALUE_WIDTH-1]
                              ? (~req_chan.value + dasc_pkg::VALUE_WIDTH'(1))
                              : req_chan.value;
               bcd_in       = '0;
               shift_cnt_in = '0;
               state_in     = dasc_pkg::ST_CONVERT;
            end
         end
         dasc_pkg::ST_CONVERT: begin
            bcd_in       = {bcd_adj[dasc_pkg::BCD_WIDTH-2:0], mag_ff[dasc_pkg::VALUE_WIDTH-1]};
            mag_in       = {mag_ff[dasc_pkg::VALUE_WIDTH-2:0], 1'b0};
            shift_cnt_in = shift_cnt_ff + dasc_pkg::SHIFT_CNT_WIDTH'(1);
            if (shift_cnt_ff == dasc_pkg::SHIFT_CNT_WIDTH'(dasc_pkg::VALUE_WIDTH - 1)) begin
               digits_in = dasc_pkg::DIGIT_CNT_WIDTH'(dasc_pkg::DIGIT_COUNT);
               state_in  = dasc_pkg::ST_ALIGN;
            end
         end
         dasc_pkg::ST_ALIGN: begin
            if ((top_digit == 4'd0) && !last_digit) begin
               bcd_in    = {bcd_ff[dasc_pkg::BCD_WIDTH-5:0], 4'd0};
               digits_in = digits_ff - dasc_pkg::DIGIT_CNT_WIDTH'(1);
            end else if (neg_ff) begin
               state_in = dasc_pkg::ST_SIGN;
            end else begin
               state_in = dasc_pkg::ST_EMIT;
            end
         end
         dasc_pkg::ST_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = dasc_pkg::ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = dasc_pkg::ST_EMIT;
            end
         end
         dasc_pkg::ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = dasc_pkg::ASCII_ZERO + {4'd0, top_digit};
               out_last_in  = last_digit;
               bcd_in       = {bcd_ff[dasc_pkg::BCD_WIDTH-5:0], 4'd0};
               digits_in    = digits_ff - dasc_pkg::DIGIT_CNT_WIDTH'(1);
               if (last_digit) begin
                  state_in = dasc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dasc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dasc_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      neg_ff       <= neg_in;
      shift_cnt_ff <= shift_cnt_in;
      digits_ff    <= digits_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

endmodule

`default_nettype wire

// ===== bench/int_to_decimal_ascii_test.sv =====
// Self-checking bench for the signed integer to decimal ASCII printer.
`timescale 1ns / 1ps

module int_to_decimal_ascii_test;

   localparam int          RESET_CYCLES    = 12;
   localparam int          ITEMS_PER_PHASE = 82;
   localparam int          PHASE_COUNT     = 5;
   localparam int          PRESSURE_CYCLES = 400;
   localparam int          DRAIN_CYCLES    = 64;
   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int          DIRECTED_COUNT  = 22;

   typedef enum int {
      MODE_STEADY,
      MODE_SENDER_GAPS,
      MODE_RECEIVER_STALLS,
      MODE_BOTH,
      MODE_BACKPRESSURE
   } traffic_mode_type;

   typedef struct packed {
      logic [dasc_pkg::CHAR_WIDTH-1:0] character;
      logic                            last;
   } ascii_char_type;

   typedef struct {
      logic [dasc_pkg::VALUE_WIDTH-1:0] value;
      string                            text;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   dasc_req_if req_bus ();
   dasc_rsp_if rsp_bus ();

   int_to_decimal_ascii dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   ascii_char_type   expected_chars [$];
   int               mismatch_count     = 0;
   int unsigned      cycle_count        = 0;
   traffic_mode_type traffic            = MODE_STEADY;
   int               sender_gap_pct     = 0;
   int               receiver_stall_pct = 0;
   bit               pressure_done      = 1'b0;

   // Typed text where the answer is obvious, otherwise the predictor decides.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{32'h0000_0000, "0"},
      '{32'h0000_0001, "1"},
      '{32'hFFFF_FFFF, "-1"},
      '{32'h0000_0009, "9"},
      '{32'h0000_000A, "10"},
      '{32'hFFFF_FFF6, "-10"},
      '{32'h7FFF_FFFF, "2147483647"},
      '{32'h8000_0000, "-2147483648"},
      '{32'h8000_0001, "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999, "999999999"},
      '{32'd99, ""},
      '{32'd100, ""},
      '{32'd12345, ""},
      '{32'hC521_974F, ""},
      '{32'h5555_5555, ""},
      '{32'hAAAA_AAAA, ""},
      '{32'h7FFF_0000, ""},
      '{32'h0000_FFFF, ""},
      '{32'hFFFF_FF9C, ""},
      '{32'hEE6B_2800, ""},
      '{32'd42, ""}
   };

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int expected, input int actual);
      $display("MISMATCH %s: expected %0d, got %0d at cycle %0d",
               what, expected, actual, cycle_count);
      mismatch_count++;
   endtask

   task automatic queue_decimal_text(input logic [dasc_pkg::VALUE_WIDTH-1:0] value);
      logic [dasc_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [3:0]                       digits [dasc_pkg::DIGIT_COUNT];
      int                               digit_total;
      ascii_char_type                   entry;
      digit_total = 0;
      magnitude = value[dasc_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      do begin
         digits[digit_total] = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         digit_total++;
      end while (magnitude != 0 && digit_total < dasc_pkg::DIGIT_COUNT);
      if (value[dasc_pkg::VALUE_WIDTH-1]) begin
         entry.character = dasc_pkg::ASCII_MINUS;
         entry.last = 1'b0;
         expected_chars.push_back(entry);
      end
      for (int k = digit_total; k > 0; k--) begin
         entry.character = dasc_pkg::CHAR_WIDTH'(dasc_pkg::ASCII_ZERO + digits[k-1]);
         entry.last = (k == 1);
         expected_chars.push_back(entry);
      end
   endtask

   function automatic logic [dasc_pkg::VALUE_WIDTH-1:0] pick_random_value();
      logic [dasc_pkg::VALUE_WIDTH-1:0] v;
      longint unsigned                  power;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom_range(200) - 100;
         6, 7: begin
            power = 1;
            repeat ($urandom_range(9)) power = power * 10;
            v = power[dasc_pkg::VALUE_WIDTH-1:0] + $urandom_range(2) - 1;
            if ($urandom_range(1)) v = ~v + 1'b1;
         end
         8: begin
            v = $urandom >> $urandom_range(31);
            if ($urandom_range(1)) v = ~v + 1'b1;
         end
         default: begin
            case ($urandom_range(3))
               0:       v = 32'h8000_0000;
               1:       v = 32'h7FFF_FFFF;
               2:       v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return v;
   endfunction

   // Called at a rising edge; returns at the edge where the transaction happens.
   task automatic offer_value(input logic [dasc_pkg::VALUE_WIDTH-1:0] value);
      logic accepted;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_bus.ready;
         @(posedge clock);
      end
   endtask

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (traffic == MODE_BACKPRESSURE && !pressure_done) begin
            hold_left = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", -1, rsp_bus.character);
         end else begin
            if (rsp_bus.character !== expected_chars[0].character)
               report_mismatch("character", expected_chars[0].character, rsp_bus.character);
            if (rsp_bus.last !== expected_chars[0].last)
               report_mismatch("last", expected_chars[0].last, rsp_bus.last);
            void'(expected_chars.pop_front());
         end
      end
   end

   initial begin : stimulus
      logic [dasc_pkg::VALUE_WIDTH-1:0] v;
      ascii_char_type                   entry;
      int                               len;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_value(directed_rows[i].value);
         len = directed_rows[i].text.len();
         if (len > 0) begin
            for (int c = 0; c < len; c++) begin
               entry.character = directed_rows[i].text[c];
               entry.last = (c == len - 1);
               expected_chars.push_back(entry);
            end
         end else begin
            queue_decimal_text(directed_rows[i].value);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               traffic = MODE_STEADY;
               sender_gap_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               traffic = MODE_SENDER_GAPS;
               sender_gap_pct = 63;
               receiver_stall_pct = 0;
            end
            2: begin
               traffic = MODE_RECEIVER_STALLS;
               sender_gap_pct = 0;
               receiver_stall_pct = 63;
            end
            3: begin
               traffic = MODE_BOTH;
               sender_gap_pct = 19;
               receiver_stall_pct = 19;
            end
            default: begin
               traffic = MODE_BACKPRESSURE;
               sender_gap_pct = 0;
               receiver_stall_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            v = pick_random_value();
            offer_value(v);
            queue_decimal_text(v);
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dasc_pkg.sv
hw/rtl/dasc_req_if.sv
hw/rtl/dasc_rsp_if.sv
hw/rtl/int_to_decimal_ascii.sv
bench/int_to_decimal_ascii_test.sv
